/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/adsq_pkg.sv */
// ----------------------------------------------------------------------------
// adsq_pkg
// Shared widths, register codes and structs of the ADC scan sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package adsq_pkg;

  localparam int SENSOR_COUNT_DEF = 6;
  localparam int SAMPLE_BITS      = 10;
  localparam int CHAN_W           = 3;
  localparam int SLOT_W           = 4;
  localparam int PHASE_W          = 5;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 3;

  localparam logic [CHAN_W-1:0] DUMMY_CHANNEL = 3'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EMITTER_ENABLE  = 2'd0,
    CFG_BATTERY_CHANNEL = 2'd1,
    CFG_SWITCH_CHANNEL  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic              emitter_enable;
    logic [CHAN_W-1:0] battery_channel;
    logic [CHAN_W-1:0] switch_channel;
    logic              emitter_clear;
  } cfg_t;

  typedef struct packed {
    logic                   start_conversion;
    logic [CHAN_W-1:0]      channel;
    logic                   emitter_drive;
    logic                   scan_active;
    logic                   sample_valid;
    logic [SLOT_W-1:0]      slot;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   diff_valid;
    logic [SAMPLE_BITS-1:0] reflect_diff;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/adsq_in_if.sv */
// ----------------------------------------------------------------------------
// adsq_in_if
// Input item channel: scan start or conversion done with its result.
// ----------------------------------------------------------------------------
`default_nettype none

interface adsq_in_if;
  import adsq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [SAMPLE_BITS-1:0] adc_result;

  modport source (output valid, kind, adc_result, input ready);
  modport sink (input valid, kind, adc_result, output ready);
endinterface

`default_nettype wire

/* hw/rtl/adsq_out_if.sv */
// ----------------------------------------------------------------------------
// adsq_out_if
// Result item channel: conversion request, emitter level and samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface adsq_out_if;
  import adsq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   start_conversion;
  logic [CHAN_W-1:0]      channel;
  logic                   emitter_drive;
  logic                   scan_active;
  logic                   sample_valid;
  logic [SLOT_W-1:0]      slot;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   diff_valid;
  logic [SAMPLE_BITS-1:0] reflect_diff;

  modport source (output valid, start_conversion, channel, emitter_drive, scan_active,
                  sample_valid, slot, sample, diff_valid, reflect_diff, input ready);
  modport sink (input valid, start_conversion, channel, emitter_drive, scan_active,
                sample_valid, slot, sample, diff_valid, reflect_diff, output ready);
endinterface

`default_nettype wire

/* hw/rtl/adsq_cfg_if.sv */
// ----------------------------------------------------------------------------
// adsq_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface adsq_cfg_if;
  import adsq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/adsq_cfg.sv */
// ----------------------------------------------------------------------------
// adsq_cfg
// Configuration registers; a write to emitter_enable also clears the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module adsq_cfg (
  input  wire logic     clk,
  input  wire logic     rst,
  adsq_cfg_if.sink      cfg,
  output adsq_pkg::cfg_t settings
);
  import adsq_pkg::*;

  logic              emitter_enable;
  logic [CHAN_W-1:0] battery_channel;
  logic [CHAN_W-1:0] switch_channel;
  logic              wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      emitter_enable  <= 1'b1;
      battery_channel <= 3'd7;
      switch_channel  <= 3'd6;
    end else if (wr) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_EMITTER_ENABLE:  emitter_enable  <= cfg.data[0];
        CFG_BATTERY_CHANNEL: battery_channel <= cfg.data[CHAN_W-1:0];
        CFG_SWITCH_CHANNEL:  switch_channel  <= cfg.data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    settings.emitter_enable  = emitter_enable;
    settings.battery_channel = battery_channel;
    settings.switch_channel  = switch_channel;
    settings.emitter_clear   = wr && (cfg.index == CFG_EMITTER_ENABLE);
  end
endmodule

`default_nettype wire

/* hw/rtl/adsq_step.sv */
// ----------------------------------------------------------------------------
// adsq_step
// Scan phase state, dark reading store and the per-item step logic.
// ----------------------------------------------------------------------------
`default_nettype none

module adsq_step #(
  parameter int SENSOR_COUNT = adsq_pkg::SENSOR_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             fire,
  input  wire logic                             kind,
  input  wire logic [adsq_pkg::SAMPLE_BITS-1:0] adc_result,
  input  wire adsq_pkg::cfg_t                   settings,
  output adsq_pkg::result_t                     res
);
  import adsq_pkg::*;

  localparam int DIW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam logic [PHASE_W-1:0] PH_BATT     = PHASE_W'(1);
  localparam logic [PHASE_W-1:0] PH_SW       = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] PH_DARK0    = PHASE_W'(3);
  localparam logic [PHASE_W-1:0] PH_LASTDARK = PHASE_W'(2 + SENSOR_COUNT);
  localparam logic [PHASE_W-1:0] PH_SETTLE   = PHASE_W'(3 + SENSOR_COUNT);
  localparam logic [PHASE_W-1:0] PH_LIT0     = PHASE_W'(4 + SENSOR_COUNT);
  localparam logic [PHASE_W-1:0] PH_LAST     = PHASE_W'(3 + 2 * SENSOR_COUNT);

  logic [PHASE_W-1:0]     phase, phase_next;
  logic                   active, active_next;
  logic                   emitter_level, emitter_level_next;
  logic [SAMPLE_BITS-1:0] dark_store [SENSOR_COUNT];
  logic                   dark_wr;
  logic [PHASE_W-1:0]     dark_off, lit_off, lit_chan, ph_m1, ph_m2;
  logic [SAMPLE_BITS-1:0] dark_val;

  assign dark_off = phase - PH_DARK0;
  assign lit_off  = phase - PH_LIT0;
  assign lit_chan = lit_off + PHASE_W'(1);
  assign ph_m1    = phase - PHASE_W'(1);
  assign ph_m2    = phase - PHASE_W'(2);
  assign dark_val = dark_store[lit_off[DIW-1:0]];

  always_comb begin
    res                = '0;
    phase_next         = phase;
    active_next        = active;
    emitter_level_next = emitter_level;
    dark_wr            = 1'b0;
    if (!kind) begin
      phase_next           = '0;
      active_next          = 1'b1;
      res.start_conversion = 1'b1;
    end else if (active) begin
      phase_next = phase + PHASE_W'(1);
      if (phase == '0) begin
        res.start_conversion = 1'b1;
        res.channel          = settings.battery_channel;
      end else if (phase == PH_BATT) begin
        res.sample_valid     = 1'b1;
        res.slot             = ph_m1[SLOT_W-1:0];
        res.sample           = adc_result;
        res.start_conversion = 1'b1;
        res.channel          = settings.switch_channel;
      end else if (phase == PH_SW) begin
        res.sample_valid     = 1'b1;
        res.slot             = ph_m1[SLOT_W-1:0];
        res.sample           = adc_result;
        res.start_conversion = 1'b1;
      end else if (phase >= PH_DARK0 && phase <= PH_LASTDARK) begin
        dark_wr              = 1'b1;
        res.sample_valid     = 1'b1;
        res.slot             = ph_m1[SLOT_W-1:0];
        res.sample           = adc_result;
        res.start_conversion = 1'b1;
        if (phase == PH_LASTDARK) begin
          emitter_level_next = emitter_level | settings.emitter_enable;
          res.channel        = DUMMY_CHANNEL;
        end else begin
          res.channel = ph_m2[CHAN_W-1:0];
        end
      end else if (phase == PH_SETTLE) begin
        res.start_conversion = 1'b1;
      end else if (phase >= PH_LIT0 && phase <= PH_LAST) begin
        res.sample_valid = 1'b1;
        res.slot         = ph_m2[SLOT_W-1:0];
        res.sample       = adc_result;
        res.diff_valid   = 1'b1;
        res.reflect_diff = (adc_result > dark_val) ? (adc_result - dark_val) : '0;
        if (phase == PH_LAST) begin
          emitter_level_next = 1'b0;
          active_next        = 1'b0;
        end else begin
          res.start_conversion = 1'b1;
          res.channel          = lit_chan[CHAN_W-1:0];
        end
      end else begin
        active_next = 1'b0;
      end
    end
    res.emitter_drive = emitter_level_next;
    res.scan_active   = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= '0;
      active        <= 1'b0;
      emitter_level <= 1'b0;
    end else begin
      if (fire) begin
        phase  <= phase_next;
        active <= active_next;
      end
      if (settings.emitter_clear) begin
        emitter_level <= 1'b0;
      end else if (fire) begin
        emitter_level <= emitter_level_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && dark_wr) begin
      dark_store[dark_off[DIW-1:0]] <= adc_result;
    end
  end
endmodule

`default_nettype wire

/* hw/rtl/adc_scan_dark_lit_sequencer.sv */
// Path: an accepted item waits in the input register until the result register can take its result.
// Throughput: one item per cycle while the output is not stalled; the single-pass step logic between the input
// register and the result register sets this figure.
// Reset: phase, scan and emitter go idle/off, registers return to their defaults,
// both pipeline registers empty; dark readings stay undefined until a scan writes them.
// ----------------------------------------------------------------------------
// adc_scan_dark_lit_sequencer
// Top level: input register, step logic, result register and configuration.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module adc_scan_dark_lit_sequencer #(
  parameter int SENSOR_COUNT = adsq_pkg::SENSOR_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  adsq_in_if.sink   adc,
  adsq_out_if.source scan,
  adsq_cfg_if.sink  cfg
);
  import adsq_pkg::*;

  cfg_t                   settings;
  result_t                res, res_q;
  logic                   in_valid_q;
  logic                   kind_q;
  logic [SAMPLE_BITS-1:0] adc_q;
  logic                   out_valid;
  logic                   adv;
  logic                   fire;

  assign adv       = !out_valid || scan.ready;
  assign fire      = in_valid_q && adv;
  assign adc.ready = !in_valid_q || adv;

  adsq_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .settings (settings)
  );

  adsq_step #(
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .kind       (kind_q),
    .adc_result (adc_q),
    .settings   (settings),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (adc.ready) begin
        in_valid_q <= adc.valid;
      end
      if (adv) begin
        out_valid <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adc.valid && adc.ready) begin
      kind_q <= adc.kind;
      adc_q  <= adc.adc_result;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign scan.valid            = out_valid;
  assign scan.start_conversion = res_q.start_conversion;
  assign scan.channel          = res_q.channel;
  assign scan.emitter_drive    = res_q.emitter_drive;
  assign scan.scan_active      = res_q.scan_active;
  assign scan.sample_valid     = res_q.sample_valid;
  assign scan.slot             = res_q.slot;
  assign scan.sample           = res_q.sample;
  assign scan.diff_valid       = res_q.diff_valid;
  assign scan.reflect_diff     = res_q.reflect_diff;

  `ASSERT_NEXT(a_hold_pending, clk, rst, in_valid_q && !adv, in_valid_q)
  `ASSERT_IMPLY(a_stall_only_on_out, clk, rst, !adc.ready, scan.valid && !scan.ready)
  `ASSERT_IMPLY(a_diff_has_sample, clk, rst, scan.valid && scan.diff_valid, scan.sample_valid)
  `ASSERT_IMPLY(a_idle_chan_zero, clk, rst, scan.valid && !scan.start_conversion, scan.channel == '0)
endmodule

`default_nettype wire
